// File: rtl/bsqd_pkg.sv
// ----------------------------------------------------------------------------
// bsqd_pkg
// Shared types and constants for the bounded stack/queue deque.
// ----------------------------------------------------------------------------
package bsqd_pkg;

  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultDataWidth = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT   = 2'd0,
    CMD_APPEND_BACK  = 2'd1,
    CMD_REMOVE_FRONT = 2'd2,
    CMD_QUERY        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_LOAD
  } cell_op_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] data_in;
  } in_t;

  typedef struct packed {
    logic [31:0] removed_word;
    logic [31:0] head_word;
    logic [31:0] tail_word;
    logic [4:0]  entry_count;
    logic        is_empty;
    status_e     status;
  } out_t;

endpackage

// File: rtl/bounded_stack_queue_deque.sv
// ----------------------------------------------------------------------------
// bounded_stack_queue_deque
// Bounded deque built as a shifting chain of cells: push front shifts the
// chain back, remove front shifts it forward, append loads the first free cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | in_i  (bsqd_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i | out_o (bsqd_pkg::out_t)
//
//  One command per cycle; its result appears in the output register on the
//  next cycle. The chain shift and the count/tail registers settle each
//  command along with the output register. Reset clears the count and
//  output valid; cell contents are not reset. A stalled output holds back
//  input only while the output register is occupied and not being taken.
// ----------------------------------------------------------------------------
module bounded_stack_queue_deque #(
  parameter int unsigned Depth     = bsqd_pkg::DefaultDepth,
  parameter int unsigned DataWidth = bsqd_pkg::DefaultDataWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bsqd_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bsqd_pkg::out_t out_o
);
  import bsqd_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataWidth-1:0] cell_data [Depth];
  cell_op_e             cell_op   [Depth];
  logic [DataWidth-1:0] word;

  logic [CntW-1:0]      count_d, count_q;
  logic [DataWidth-1:0] tail_d, tail_q;
  logic                 out_valid_d, out_valid_q;
  out_t                 out_d, out_q;

  logic                 fire, full, empty;
  logic                 shift_in, shift_out, load;
  logic [DataWidth-1:0] removed, head;
  status_e              status;

  assign word  = DataWidth'(in_i.data_in);
  assign fire  = in_valid_i && in_ready_o;
  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);

  always_comb begin
    shift_in  = 1'b0;
    shift_out = 1'b0;
    load      = 1'b0;
    count_d   = count_q;
    tail_d    = tail_q;
    status    = ST_OK;
    removed   = '0;
    head      = cell_data[0];
    unique case (in_i.command)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          shift_in = 1'b1;
          count_d  = count_q + 1'b1;
          head     = word;
          if (empty) begin
            tail_d = word;
          end
        end
      end
      CMD_APPEND_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          load    = 1'b1;
          count_d = count_q + 1'b1;
          tail_d  = word;
          if (empty) begin
            head = word;
          end
        end
      end
      CMD_REMOVE_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          shift_out = 1'b1;
          count_d   = count_q - 1'b1;
          removed   = cell_data[0];
          head      = cell_data[1];
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataWidth-1:0] front_in, back_in;

    if (i == 0) begin : g_first
      assign front_in = word;
    end else begin : g_mid
      assign front_in = cell_data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign back_in = cell_data[i];
    end else begin : g_inner
      assign back_in = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (fire) begin
        priority if (shift_in) begin
          cell_op[i] = CELL_SHIFT_IN;
        end else if (shift_out) begin
          cell_op[i] = CELL_SHIFT_OUT;
        end else if (load && (count_q == CntW'(i))) begin
          cell_op[i] = CELL_LOAD;
        end else begin
          cell_op[i] = CELL_HOLD;
        end
      end
    end

    bsqd_cell #(
      .DataWidth(DataWidth)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[i]),
      .front_i(front_in),
      .back_i (back_in),
      .load_i (word),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    out_d              = out_q;
    out_d.removed_word = 32'(removed);
    out_d.head_word    = (count_d != '0) ? 32'(head) : '0;
    out_d.tail_word    = (count_d != '0) ? 32'(tail_d) : '0;
    out_d.entry_count  = 5'(count_d);
    out_d.is_empty     = (count_d == '0);
    out_d.status       = status;
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_d = fire ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tail_q <= tail_d;
      out_q  <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_i.command == CMD_PUSH_FRONT) && !full
    |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("push did not grow the count");

  a_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_i.command == CMD_REMOVE_FRONT) && empty
    |=> out_valid_o && (out_o.status == ST_EMPTY) && (count_q == '0))
    else $error("remove from empty not flagged");

  a_out_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_o.is_empty == (count_q == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

// File: rtl/bsqd_cell.sv
// ----------------------------------------------------------------------------
// bsqd_cell
// One entry of the deque chain: holds a word, takes it from the front-side
// neighbor, the back-side neighbor or the load bus.
// ----------------------------------------------------------------------------
module bsqd_cell #(
  parameter int unsigned DataWidth = 32
) (
  input  logic                    clk_i,
  input  bsqd_pkg::cell_op_e      op_i,
  input  logic [DataWidth-1:0]    front_i,
  input  logic [DataWidth-1:0]    back_i,
  input  logic [DataWidth-1:0]    load_i,
  output logic [DataWidth-1:0]    data_o
);
  import bsqd_pkg::*;

  logic [DataWidth-1:0] data_d, data_q;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:      data_d = data_q;
      CELL_SHIFT_IN:  data_d = front_i;
      CELL_SHIFT_OUT: data_d = back_i;
      CELL_LOAD:      data_d = load_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: dv/bounded_stack_queue_deque_tb.sv
// ----------------------------------------------------------------------------
// bounded_stack_queue_deque_tb
// Self-checking testbench for the bounded stack/queue deque. A directed
// sequence covers the empty and full corners, word extremes and every command.
// Randomized commands follow, with fill, drain and balanced phases. Each
// accepted command is run through a scoreboard that models the ring, and
// every result is compared field by field. Both handshakes stall at random,
// and there is one long output hold-off and one pause until drained.
// ----------------------------------------------------------------------------
module bounded_stack_queue_deque_tb;
  import bsqd_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int unsigned RandItems  = 1750;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned MaxPrints  = 100;

  class deque_scoreboard;
    logic [31:0] words [Depth];
    logic [3:0]  front;
    logic [4:0]  count;
    out_t        expected_q [$];
    int unsigned errors;

    function new();
      front  = '0;
      count  = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(in_t cmd_in);
      out_t       r;
      logic [3:0] idx;
      r = '0;
      r.status = ST_OK;
      case (cmd_in.command)
        CMD_PUSH_FRONT, CMD_APPEND_BACK: begin
          if (count == Depth) begin
            r.status = ST_FULL;
          end else if (cmd_in.command == CMD_PUSH_FRONT) begin
            front = front - 4'd1;
            words[front] = cmd_in.data_in;
            count++;
          end else begin
            idx = front + count[3:0];
            words[idx] = cmd_in.data_in;
            count++;
          end
        end
        CMD_REMOVE_FRONT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.removed_word = words[front];
            front = front + 4'd1;
            count--;
          end
        end
        default: ;
      endcase
      if (count != 0) begin
        idx = front + count[3:0] - 4'd1;
        r.head_word = words[front];
        r.tail_word = words[idx];
      end
      r.entry_count = count;
      r.is_empty    = (count == 0);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MaxPrints)
        $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, head_word", got.head_word, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.removed_word !== want.removed_word)
        report_mismatch("removed_word", got.removed_word, want.removed_word);
      if (got.head_word !== want.head_word)
        report_mismatch("head_word", got.head_word, want.head_word);
      if (got.tail_word !== want.tail_word)
        report_mismatch("tail_word", got.tail_word, want.tail_word);
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      if (got.is_empty !== want.is_empty)
        report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  deque_scoreboard sb = new();
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  bounded_stack_queue_deque dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** bounded_stack_queue_deque: FAILED **");
      $finish;
    end
  end

  // transfer monitors: command first, then result
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_o);
    end
  end

  // result receiver
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task send_item(cmd_e cmd, logic [31:0] word);
    int unsigned gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 14) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_i.command   <= cmd;
    in_i.data_in   <= word;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task drain_wait();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 is balanced
  function automatic cmd_e pick_cmd(int unsigned mode);
    int unsigned r;
    int unsigned ins;
    r = $urandom_range(99);
    case (mode)
      0:       ins = 75;
      1:       ins = 20;
      default: ins = 45;
    endcase
    if (r < ins) return ($urandom_range(1) == 0) ? CMD_PUSH_FRONT : CMD_APPEND_BACK;
    if (r < 92) return CMD_REMOVE_FRONT;
    return CMD_QUERY;
  endfunction

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty corners, extremes, fill to full, overflow
    send_item(CMD_QUERY, 32'h1234_5678);
    send_item(CMD_REMOVE_FRONT, '1);
    send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(CMD_APPEND_BACK, 32'h0000_0000);
    send_item(CMD_REMOVE_FRONT, '0);
    send_item(CMD_REMOVE_FRONT, '0);
    send_item(CMD_REMOVE_FRONT, '0);
    for (int unsigned i = 0; i < Depth; i++) begin
      send_item((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_APPEND_BACK,
                (i % 4 < 2) ? (32'hA5A5_A500 | i) : (32'h5A5A_5A00 | i));
    end
    send_item(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    send_item(CMD_APPEND_BACK, 32'hCAFE_F00D);

    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 600) calm = 1'b1;
      if (i == 1000) begin
        calm = 1'b0;
        drain_wait();
      end
      send_item(pick_cmd((i / 40) % 3), pick_word());
    end

    drain_wait();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** bounded_stack_queue_deque: PASSED **");
    end else begin
      $display("** bounded_stack_queue_deque: FAILED **");
    end
    $finish;
  end

endmodule
